// File: hw/rtl/gsa_pkg.sv
// Shared types, constants and codes for the global sequence aligner.
package gsa_pkg;

	// Default sizing of the core.
	localparam int MAX_LEN_DEF     = 32;
	localparam int SCORE_WIDTH_DEF = 16;

	// Field widths of the command word, sized for the largest sequence length.
	localparam int ADDR_W_MAX = 5;
	localparam int CNT_W_MAX  = 6;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_LONG  = 2'd2;

	// Store write operations carried by a command word.
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_WR1  = 2'd1;
	localparam logic [1:0] OP_WR2  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	// Byte used for a wildcard column.
	localparam logic [7:0] WILD_BYTE = 8'hff;

	// One input word.
	typedef struct packed {
		logic       req_type;
		logic [7:0] symbol;
		logic       end_of_sequence;
	} in_item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] first_symbol;
		logic       first_gap;
		logic [7:0] second_symbol;
		logic       second_gap;
		logic [7:0] merged_symbol;
		logic       wildcard_res;
		logic [1:0] status;
		logic       final_column;
	} out_item_t;

	// Command from the front end to the alignment engine.
	typedef struct packed {
		logic [1:0]            op;
		logic [ADDR_W_MAX-1:0] addr;
		logic [7:0]            sym;
		logic                  run;
		logic [1:0]            status;
		logic [CNT_W_MAX-1:0]  n1;
		logic [CNT_W_MAX-1:0]  n2;
	} cmd_t;

endpackage

// File: hw/rtl/gsa_fifo.sv
// Small register queue between the front end and the alignment engine.
module gsa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointer and fill count upkeep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hw/rtl/gsa_front.sv
// Front end: counts incoming bytes, flags overflow and issues store and run commands.
module gsa_front #(
	parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  gsa_pkg::in_item_t item,
	output gsa_pkg::cmd_t     cmd
);
	import gsa_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0] cnt1_q;
	logic [CW-1:0] cnt2_q;
	logic          ovf1_q;
	logic          ovf2_q;
	logic          room1;
	logic          room2;
	logic [CW-1:0] cnt2_nxt;
	logic          ovf2_nxt;
	logic          run;

	assign room1    = (cnt1_q != CW'(MAX_LEN));
	assign room2    = (cnt2_q != CW'(MAX_LEN));
	assign cnt2_nxt = (item.req_type && room2) ? cnt2_q + 1'b1 : cnt2_q;
	assign ovf2_nxt = ovf2_q || (item.req_type && !room2);
	assign run      = item.req_type && item.end_of_sequence;

	// Build the command for the word at the input.
	always_comb begin
		cmd        = '0;
		cmd.sym    = item.symbol;
		cmd.run    = run;
		cmd.n1     = CNT_W_MAX'(cnt1_q);
		cmd.n2     = CNT_W_MAX'(cnt2_nxt);
		if (!item.req_type) begin
			cmd.op   = room1 ? OP_WR1 : OP_NONE;
			cmd.addr = ADDR_W_MAX'(cnt1_q);
		end else begin
			cmd.op   = room2 ? OP_WR2 : OP_NONE;
			cmd.addr = ADDR_W_MAX'(cnt2_q);
		end
		if (ovf1_q || ovf2_nxt) begin
			cmd.status = STAT_LONG;
		end else if (cnt1_q < CW'(2) || cnt2_nxt < CW'(2)) begin
			cmd.status = STAT_SHORT;
		end else begin
			cmd.status = STAT_OK;
		end
	end

	// Sequence counters; a run start clears them for the next pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			ovf1_q <= 1'b0;
			ovf2_q <= 1'b0;
		end else if (accept) begin
			if (run) begin
				cnt1_q <= '0;
				cnt2_q <= '0;
				ovf1_q <= 1'b0;
				ovf2_q <= 1'b0;
			end else if (!item.req_type) begin
				if (room1) begin
					cnt1_q <= cnt1_q + 1'b1;
				end else begin
					ovf1_q <= 1'b1;
				end
			end else begin
				cnt2_q <= cnt2_nxt;
				ovf2_q <= ovf2_nxt;
			end
		end
	end

endmodule

// File: hw/rtl/gsa_engine.sv
// Alignment engine: sequence stores, score grid fill, traceback and column output.
module gsa_engine #(
	parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF,
	parameter int SW      = gsa_pkg::SCORE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  gsa_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic signed [7:0]  match_score,
	input  logic signed [7:0]  mismatch_score,
	input  logic signed [7:0]  gap_score,
	output logic               empty,
	input  logic               pop,
	output gsa_pkg::out_item_t res
);
	import gsa_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int GA = 2 * AW;
	localparam int KW = AW + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FRD  = 4'd1;
	localparam logic [3:0] S_FCAL = 4'd2;
	localparam logic [3:0] S_TL   = 4'd3;
	localparam logic [3:0] S_TD   = 4'd4;
	localparam logic [3:0] S_TT   = 4'd5;
	localparam logic [3:0] S_TDEC = 4'd6;
	localparam logic [3:0] S_ORD  = 4'd7;
	localparam logic [3:0] S_OLD  = 4'd8;
	localparam logic [3:0] S_ERR  = 4'd9;

	logic [3:0]           state_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        j_q;
	logic [CW-1:0]        n1_q;
	logic [CW-1:0]        n2_q;
	logic [1:0]           err_q;
	logic signed [SW-1:0] left_q;
	logic signed [SW-1:0] diag_q;
	logic signed [SW-1:0] l_q;
	logic signed [SW-1:0] d_q;
	logic [KW-1:0]        ncol_q;
	logic [KW-1:0]        k_q;
	logic                 res_valid_q;
	out_item_t            res_q;

	logic [7:0]           first_store [MAX_LEN];
	logic [7:0]           second_store [MAX_LEN];
	logic [7:0]           first_rd_q;
	logic [7:0]           second_rd_q;
	logic signed [SW-1:0] grid [2**GA];
	logic signed [SW-1:0] grid_rd_q;
	logic [17:0]          colbuf [2**KW];
	logic [17:0]          col_rd_q;

	logic [GA-1:0]        grid_raddr;
	logic                 grid_we;
	logic signed [SW-1:0] t_val;
	logic signed [SW-1:0] sd;
	logic signed [SW-1:0] sl;
	logic signed [SW-1:0] st;
	logic signed [SW-1:0] smax;
	logic signed [SW-1:0] tb_l;
	logic signed [SW-1:0] tb_d;
	logic signed [SW-1:0] tb_t;
	logic                 go_left;
	logic                 go_up;
	logic [AW-1:0]        i_nxt;
	logic [AW-1:0]        j_nxt;
	logic [17:0]          col_word;
	logic                 row_end;
	logic                 fill_end;
	logic                 out_free;
	logic                 res_load;
	logic                 c_g1;
	logic                 c_g2;
	logic                 c_wild;

	// Saturating add of a score and an 8-bit signed increment.
	function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] a,
			logic signed [7:0] b);
		logic signed [SW:0] s;
		s = (SW+1)'(a) + (SW+1)'(b);
		if (s[SW] != s[SW-1]) begin
			sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat_add = s[SW-1:0];
		end
	endfunction

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign out_free = !res_valid_q || pop;
	assign res_load = ((state_q == S_OLD) || (state_q == S_ERR)) && out_free;
	assign empty    = !res_valid_q;
	assign res      = res_q;

	// Grid read address follows the step of the fill or the traceback.
	always_comb begin
		unique case (state_q)
			S_TL:    grid_raddr = {i_q, j_q - 1'b1};
			S_TD:    grid_raddr = {i_q - 1'b1, j_q - 1'b1};
			default: grid_raddr = {i_q - 1'b1, j_q};
		endcase
	end

	// Cell score: best of diagonal, left and upper; row zero reads as zero.
	assign t_val = (i_q == AW'(1)) ? '0 : grid_rd_q;
	always_comb begin
		sd   = sat_add(diag_q, (first_rd_q == second_rd_q) ? match_score : mismatch_score);
		sl   = sat_add(left_q, gap_score);
		st   = sat_add(t_val, gap_score);
		smax = (sd > sl) ? sd : sl;
		smax = (smax > st) ? smax : st;
	end
	assign grid_we  = (state_q == S_FCAL);
	assign row_end  = (CW'(j_q) == n2_q - 1'b1);
	assign fill_end = row_end && (CW'(i_q) == n1_q - 1'b1);

	// Traceback step decision; neighbors in row or column zero read as zero.
	always_comb begin
		tb_l    = (j_q == AW'(1)) ? '0 : l_q;
		tb_d    = (i_q == AW'(1) || j_q == AW'(1)) ? '0 : d_q;
		tb_t    = (i_q == AW'(1)) ? '0 : grid_rd_q;
		go_left = (tb_l > tb_d) && (tb_l > tb_t);
		go_up   = !go_left && (tb_t >= tb_l) && (tb_t > tb_d);
		i_nxt   = go_left ? i_q : i_q - 1'b1;
		j_nxt   = go_up ? j_q : j_q - 1'b1;
		if (go_left) begin
			col_word = {1'b0, second_rd_q, 1'b1, 8'h00};
		end else if (go_up) begin
			col_word = {1'b1, 8'h00, 1'b0, first_rd_q};
		end else begin
			col_word = {1'b0, second_rd_q, 1'b0, first_rd_q};
		end
	end

	// Output column decode from the buffered traceback word.
	assign c_g1   = col_rd_q[8];
	assign c_g2   = col_rd_q[17];
	assign c_wild = c_g1 || c_g2 || (col_rd_q[7:0] != col_rd_q[16:9]);

	// Memories: stores, score grid and column buffer, all with registered reads.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_WR1) begin
			first_store[cmd.addr[AW-1:0]] <= cmd.sym;
		end
		if (cmd_pop && cmd.op == OP_WR2) begin
			second_store[cmd.addr[AW-1:0]] <= cmd.sym;
		end
		first_rd_q  <= first_store[i_q - 1'b1];
		second_rd_q <= second_store[j_q - 1'b1];
		if (grid_we) begin
			grid[{i_q, j_q}] <= smax;
		end
		grid_rd_q <= grid[grid_raddr];
		if (state_q == S_TDEC) begin
			colbuf[ncol_q] <= col_word;
		end
		col_rd_q <= colbuf[k_q];
	end

	// Sequencer over fill, traceback and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n1_q        <= '0;
			n2_q        <= '0;
			ncol_q      <= '0;
			k_q         <= '0;
			err_q       <= STAT_OK;
		end else begin
			res_valid_q <= res_load || (res_valid_q && !pop);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop && cmd.run) begin
						n1_q  <= cmd.n1[CW-1:0];
						n2_q  <= cmd.n2[CW-1:0];
						err_q <= cmd.status;
						i_q   <= AW'(1);
						j_q   <= AW'(1);
						state_q <= (cmd.status != STAT_OK) ? S_ERR : S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FCAL;
				end
				S_FCAL: begin
					if (fill_end) begin
						i_q     <= AW'(n1_q - 1'b1);
						j_q     <= AW'(n2_q - 1'b1);
						ncol_q  <= '0;
						state_q <= S_TL;
					end else begin
						if (row_end) begin
							i_q <= i_q + 1'b1;
							j_q <= AW'(1);
						end else begin
							j_q <= j_q + 1'b1;
						end
						state_q <= S_FRD;
					end
				end
				S_TL: state_q <= S_TD;
				S_TD: state_q <= S_TT;
				S_TT: state_q <= S_TDEC;
				S_TDEC: begin
					i_q    <= i_nxt;
					j_q    <= j_nxt;
					ncol_q <= ncol_q + 1'b1;
					if (i_nxt == '0 || j_nxt == '0) begin
						k_q     <= ncol_q;
						state_q <= S_ORD;
					end else begin
						state_q <= S_TL;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					if (out_free) begin
						if (k_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q - 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Fill carries and traceback neighbor captures.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (state_q == S_FCAL) begin
			left_q <= row_end ? '0 : smax;
			diag_q <= row_end ? '0 : t_val;
		end
		if (state_q == S_TD) begin
			l_q <= grid_rd_q;
		end
		if (state_q == S_TT) begin
			d_q <= grid_rd_q;
		end
	end

	// Result register load.
	always_ff @(posedge clk) begin
		if (res_load && state_q == S_OLD) begin
			res_q.first_symbol  <= col_rd_q[7:0];
			res_q.first_gap     <= c_g1;
			res_q.second_symbol <= col_rd_q[16:9];
			res_q.second_gap    <= c_g2;
			res_q.merged_symbol <= c_wild ? WILD_BYTE : col_rd_q[7:0];
			res_q.wildcard_res  <= c_wild;
			res_q.status        <= STAT_OK;
			res_q.final_column  <= (k_q == '0);
		end else if (res_load) begin
			res_q.first_symbol  <= 8'h00;
			res_q.first_gap     <= 1'b0;
			res_q.second_symbol <= 8'h00;
			res_q.second_gap    <= 1'b0;
			res_q.merged_symbol <= 8'h00;
			res_q.wildcard_res  <= 1'b0;
			res_q.status        <= err_q;
			res_q.final_column  <= 1'b1;
		end
	end

endmodule

// File: hw/rtl/global_sequence_aligner_core.sv
// Global sequence aligner: loads two byte sequences, fills a score grid, traces back and
// returns the alignment columns in forward order, one word per column. Each input word
// passes through the front end and enters a four-entry command queue; while a run is
// under way the engine leaves the queue alone, so up to four words of the next pair can
// wait there before full rises. A run started by the last byte of the second sequence
// occupies the engine for the grid fill (one read and one write of the score grid per
// cell), the traceback (three grid reads and a decision per column) and the output of
// the columns, each of which waits while the result word is not taken. An error run
// returns a single word. The user must write the score registers through the APB port
// only while the block is idle; the block itself does not enforce this.
module global_sequence_aligner_core #(
	parameter int MAX_LEN     = gsa_pkg::MAX_LEN_DEF,
	parameter int SCORE_WIDTH = gsa_pkg::SCORE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  gsa_pkg::in_item_t  req_word,
	output logic               empty,
	input  logic               pop,
	output gsa_pkg::out_item_t res_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import gsa_pkg::*;

	logic signed [7:0] match_q;
	logic signed [7:0] mismatch_q;
	logic signed [7:0] gap_q;
	logic              cfg_wr;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              accept;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = push && !full;

	// Score registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 8'sd10;
			mismatch_q <= -8'sd10;
			gap_q      <= 8'sd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MATCH:    match_q    <= pwdata[7:0];
				REG_MISMATCH: mismatch_q <= pwdata[7:0];
				REG_GAP:      gap_q      <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	// Register readback, sign extended.
	always_comb begin
		unique case (paddr[3:2])
			REG_MATCH:    prdata = 32'(match_q);
			REG_MISMATCH: prdata = 32'(mismatch_q);
			REG_GAP:      prdata = 32'(gap_q);
			default:      prdata = '0;
		endcase
	end

	gsa_front #(
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (req_word),
		.cmd    (cmd_in)
	);

	gsa_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(4)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	gsa_engine #(
		.MAX_LEN(MAX_LEN),
		.SW     (SCORE_WIDTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (cmd_empty),
		.cmd            (cmd_out),
		.cmd_pop        (cmd_pop),
		.match_score    (match_q),
		.mismatch_score (mismatch_q),
		.gap_score      (gap_q),
		.empty          (empty),
		.pop            (pop),
		.res            (res_word)
	);

endmodule

// File: hw/rtl/gsa_checker.sv
// Port-level checks for the aligner core and the bind that attaches them.
module gsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               pready,
	input gsa_pkg::out_item_t res_word
);
	import gsa_pkg::*;

	// A waiting word that is not taken stays on the ports.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res_word)))
		else $error("result word changed while waiting");

	// An error word closes its run.
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res_word.status != STAT_OK) |-> res_word.final_column)
		else $error("error word without final column");

	// A plain column has no gaps and repeats the common byte.
	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !res_word.wildcard_res) |->
		(!res_word.first_gap && !res_word.second_gap &&
		 res_word.merged_symbol == res_word.first_symbol &&
		 res_word.first_symbol == res_word.second_symbol))
		else $error("plain column inconsistent");

	// A gap on the first side carries a zero byte and excludes a gap on the second side.
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res_word.first_gap) |->
		(res_word.first_symbol == 8'h00 && !res_word.second_gap))
		else $error("gap column malformed");

	// The port is always ready.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind global_sequence_aligner_core gsa_checker u_gsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.pready   (pready),
	.res_word (res_word)
);
